>>> rtl/owsls_pkg.sv
`timescale 1ns / 1ps

package owsls_pkg;

    localparam int NUM_STEPS   = 100;
    localparam int VALUE_WIDTH = 16;
    localparam int COEF_W      = 16;
    localparam int STEP_W      = $clog2(NUM_STEPS + 1);
    localparam int NUM_WHEELS  = 4;
    localparam int NUM_PROD    = 5;
    localparam int SEL_W       = $clog2(NUM_PROD);
    localparam int PIPE_DEPTH  = 4;

    localparam int W_W  = VALUE_WIDTH + COEF_W;
    localparam int P_W  = W_W + STEP_W + 1;
    localparam int FRAC = 15;
    localparam int SH_W = P_W - FRAC;
    localparam int Q_W  = VALUE_WIDTH + 1;

    localparam longint HALF_D   = longint'(NUM_STEPS) << (FRAC - 1);
    localparam longint SAT_Q    = longint'(1) << (VALUE_WIDTH - 1);
    localparam longint U_MAX    = SAT_Q * NUM_STEPS;
    localparam int     U_W      = $clog2(U_MAX + 1);
    localparam int     RECIP_SH = U_W + $clog2(NUM_STEPS);
    localparam longint RECIP_M  = ((longint'(1) << RECIP_SH) + NUM_STEPS - 1) / NUM_STEPS;
    localparam int     M_W      = $clog2(RECIP_M + 1);
    localparam int     PR_W     = RECIP_SH + Q_W;

    localparam logic [COEF_W-1:0] C_SIN_PHI   = COEF_W'(16384);
    localparam logic [COEF_W-1:0] C_COS_PHI   = COEF_W'(28377);
    localparam logic [COEF_W-1:0] C_DIAG_X    = COEF_W'(23167);
    localparam logic [COEF_W-1:0] C_DIAG_Y    = COEF_W'(23167);
    localparam logic [COEF_W-1:0] C_RADIUS    = COEF_W'(2458);

    localparam int IN_W  = 7 * VALUE_WIDTH;
    localparam int OUT_RAW_W = 1 + 7 + NUM_WHEELS * VALUE_WIDTH + NUM_WHEELS;
    localparam int OUT_W = ((OUT_RAW_W + 7) / 8) * 8;

    typedef enum logic [SEL_W-1:0] {
        SEL_CPHI_VY   = 3'd0,
        SEL_SPHI_VX   = 3'd1,
        SEL_CTHETA_VY = 3'd2,
        SEL_STHETA_VX = 3'd3,
        SEL_RAD_OM    = 3'd4
    } prod_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_RUN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              load;
        logic              mul_en;
        prod_sel_t         mul_sel;
        logic              sum_en;
        logic              flush;
        logic              issue_valid;
        logic [STEP_W-1:0] issue_k;
        logic              flags_we;
        logic              capture;
        logic              success;
    } cmd_t;

    typedef struct packed {
        logic              res_valid;
        logic [STEP_W-1:0] res_k;
        logic              pass_all;
    } sts_t;

    function automatic logic [COEF_W-1:0] coef_of(input prod_sel_t sel);
        logic [COEF_W-1:0] c;
        unique case (sel)
            SEL_CPHI_VY:   c = C_COS_PHI;
            SEL_SPHI_VX:   c = C_SIN_PHI;
            SEL_CTHETA_VY: c = C_DIAG_Y;
            SEL_STHETA_VX: c = C_DIAG_X;
            SEL_RAD_OM:    c = C_RADIUS;
            default:       c = '0;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/owsls_lane.sv
`timescale 1ns / 1ps

module owsls_lane (
    input  logic                                      clk,
    input  logic signed [owsls_pkg::W_W-1:0]          w,
    input  logic        [owsls_pkg::STEP_W-1:0]       k,
    input  logic signed [owsls_pkg::VALUE_WIDTH-1:0]  lim,
    output logic signed [owsls_pkg::VALUE_WIDTH-1:0]  speed,
    output logic                                      pass
);
    import owsls_pkg::*;

    logic signed [P_W-1:0]         p_reg, p_next;
    logic        [U_W-1:0]         u_reg, u_next;
    logic                          neg2_reg;
    logic        [Q_W-1:0]         q_reg, q_next;
    logic                          neg3_reg;
    logic signed [VALUE_WIDTH-1:0] sp_reg, sp_next;

    logic [P_W-1:0]  mag_p;
    logic [P_W-1:0]  rnd_p;
    logic [SH_W-1:0] shr_p;
    logic [PR_W-1:0] prod;
    logic [Q_W-1:0]  neg_q;
    logic            opp;
    logic [Q_W-1:0]  mag_sp;
    logic [Q_W-1:0]  mag_lim;

    always_comb
    begin
        p_next = P_W'(w) * P_W'($signed({1'b0, k}));
    end

    always_comb
    begin
        mag_p  = p_reg[P_W-1] ? P_W'(-p_reg) : P_W'(p_reg);
        rnd_p  = mag_p + P_W'(HALF_D);
        shr_p  = rnd_p[P_W-1:FRAC];
        u_next = (shr_p > SH_W'(U_MAX)) ? U_W'(U_MAX) : U_W'(shr_p);
    end

    always_comb
    begin
        prod   = PR_W'(u_reg) * PR_W'(RECIP_M);
        q_next = prod[RECIP_SH +: Q_W];
    end

    always_comb
    begin
        neg_q = -q_reg;
        if (neg3_reg)
        begin
            sp_next = neg_q[VALUE_WIDTH-1:0];
        end
        else if (q_reg > Q_W'(SAT_Q - 1))
        begin
            sp_next = VALUE_WIDTH'(SAT_Q - 1);
        end
        else
        begin
            sp_next = q_reg[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        u_reg    <= u_next;
        neg2_reg <= p_reg[P_W-1];
        q_reg    <= q_next;
        neg3_reg <= neg2_reg;
        sp_reg   <= sp_next;
    end

    always_comb
    begin
        opp     = ((sp_reg < 0) && (lim > 0)) || ((sp_reg > 0) && (lim < 0));
        mag_sp  = sp_reg[VALUE_WIDTH-1] ? Q_W'(-Q_W'(sp_reg)) : Q_W'(sp_reg);
        mag_lim = lim[VALUE_WIDTH-1] ? Q_W'(-Q_W'(lim)) : Q_W'(lim);
        pass    = opp || (mag_sp < mag_lim);
        speed   = sp_reg;
    end

endmodule

>>> rtl/owsls_dp.sv
`timescale 1ns / 1ps

module owsls_dp (
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    input  owsls_pkg::cmd_t                                          cmd,
    output owsls_pkg::sts_t                                          sts,
    input  logic signed [owsls_pkg::VALUE_WIDTH-1:0]                 vel_x,
    input  logic signed [owsls_pkg::VALUE_WIDTH-1:0]                 vel_y,
    input  logic signed [owsls_pkg::VALUE_WIDTH-1:0]                 omega,
    input  logic signed [owsls_pkg::VALUE_WIDTH-1:0]                 wheel_limit [owsls_pkg::NUM_WHEELS],
    output logic                                                     success,
    output logic        [owsls_pkg::STEP_W-1:0]                      scale_step,
    output logic signed [owsls_pkg::VALUE_WIDTH-1:0]                 wheel_speed [owsls_pkg::NUM_WHEELS],
    output logic        [owsls_pkg::NUM_WHEELS-1:0]                  pass_flags
);
    import owsls_pkg::*;

    logic signed [VALUE_WIDTH-1:0] vx_reg, vy_reg, om_reg;
    logic signed [VALUE_WIDTH-1:0] lim_reg [NUM_WHEELS];
    logic signed [W_W-1:0]         prod_reg [NUM_PROD];
    logic signed [W_W-1:0]         w_reg [NUM_WHEELS];
    logic signed [W_W-1:0]         w_next [NUM_WHEELS];
    logic signed [W_W-1:0]         mul_res;
    logic signed [VALUE_WIDTH-1:0] mul_op;

    logic [PIPE_DEPTH-1:0] v_reg, v_next;
    logic [STEP_W-1:0]     k_reg [PIPE_DEPTH];

    logic signed [VALUE_WIDTH-1:0] lane_speed [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]         lane_pass;

    logic                          success_reg;
    logic [STEP_W-1:0]             step_reg;
    logic signed [VALUE_WIDTH-1:0] speed_reg [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]         flags_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vx_reg <= vel_x;
            vy_reg <= vel_y;
            om_reg <= omega;
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                lim_reg[i] <= wheel_limit[i];
            end
        end
    end

    always_comb
    begin
        unique case (cmd.mul_sel)
            SEL_CPHI_VY, SEL_CTHETA_VY: mul_op = vy_reg;
            SEL_SPHI_VX, SEL_STHETA_VX: mul_op = vx_reg;
            SEL_RAD_OM:                 mul_op = om_reg;
            default:                    mul_op = '0;
        endcase
        mul_res = W_W'(mul_op) * W_W'($signed({1'b0, coef_of(cmd.mul_sel)}));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg[cmd.mul_sel] <= mul_res;
        end
    end

    always_comb
    begin
        w_next[0] =  prod_reg[SEL_CPHI_VY]   - prod_reg[SEL_SPHI_VX]   + prod_reg[SEL_RAD_OM];
        w_next[1] =  prod_reg[SEL_CTHETA_VY] + prod_reg[SEL_STHETA_VX] + prod_reg[SEL_RAD_OM];
        w_next[2] = -prod_reg[SEL_CPHI_VY]   - prod_reg[SEL_SPHI_VX]   + prod_reg[SEL_RAD_OM];
        w_next[3] = -prod_reg[SEL_CTHETA_VY] + prod_reg[SEL_STHETA_VX] + prod_reg[SEL_RAD_OM];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_en)
        begin
            w_reg <= w_next;
        end
    end

    for (genvar g = 0; g < NUM_WHEELS; g++)
    begin : g_lane
        owsls_lane u_lane (
            .clk   (clk),
            .w     (w_reg[g]),
            .k     (cmd.issue_k),
            .lim   (lim_reg[g]),
            .speed (lane_speed[g]),
            .pass  (lane_pass[g])
        );
    end

    always_comb
    begin
        v_next = {v_reg[PIPE_DEPTH-2:0], cmd.issue_valid};
        if (cmd.flush)
        begin
            v_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg[0] <= cmd.issue_k;
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            k_reg[i] <= k_reg[i-1];
        end
    end

    always_comb
    begin
        sts.res_valid = v_reg[PIPE_DEPTH-1];
        sts.res_k     = k_reg[PIPE_DEPTH-1];
        sts.pass_all  = &lane_pass;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (cmd.flags_we)
        begin
            flags_reg <= lane_pass;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            success_reg <= cmd.success;
            step_reg    <= k_reg[PIPE_DEPTH-1];
            speed_reg   <= lane_speed;
        end
    end

    assign success     = success_reg;
    assign scale_step  = step_reg;
    assign wheel_speed = speed_reg;
    assign pass_flags  = flags_reg;

endmodule

>>> rtl/owsls_ctrl.sv
`timescale 1ns / 1ps

module owsls_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  owsls_pkg::sts_t sts,
    output owsls_pkg::cmd_t cmd
);
    import owsls_pkg::*;

    state_t            state_reg, state_next;
    logic [SEL_W-1:0]  idx_reg, idx_next;
    logic [STEP_W-1:0] k_reg, k_next;
    logic              done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        done       = 1'b0;
        cmd        = '0;
        cmd.mul_sel = prod_sel_t'(idx_reg);
        cmd.issue_k = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.load   = 1'b1;
                    cmd.flush  = 1'b1;
                    idx_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (idx_reg == SEL_W'(NUM_PROD - 1))
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                k_next     = STEP_W'(NUM_STEPS);
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (sts.res_valid)
                begin
                    if (sts.pass_all)
                    begin
                        done        = 1'b1;
                        cmd.success = 1'b1;
                    end
                    else
                    begin
                        cmd.flags_we = 1'b1;
                        done         = (sts.res_k == STEP_W'(1));
                    end
                end
                if (done)
                begin
                    cmd.capture = 1'b1;
                    cmd.flush   = 1'b1;
                    state_next  = ST_OUT;
                end
                else if (k_reg != '0)
                begin
                    cmd.issue_valid = 1'b1;
                    k_next          = k_reg - 1'b1;
                end
            end
            ST_OUT:
            begin
                m_valid = 1'b1;
                if (m_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid |-> !s_ready)
        else $error("input taken while a result is pending");

    a_issue_k: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue_valid |-> (cmd.issue_k != '0) && (cmd.issue_k <= STEP_W'(NUM_STEPS)))
        else $error("scale step issued out of range");

    a_flush_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> !cmd.issue_valid)
        else $error("step issued during flush");

    a_stop_on_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && sts.res_valid && sts.pass_all) |=> (state_reg == ST_OUT))
        else $error("passing step did not end the search");

endmodule

>>> rtl/omni_wheel_speed_limit_scaler.sv
`timescale 1ns / 1ps
// Omni-wheel speed limit scaler.
// Input word (s_axis): body velocity command vel_x, vel_y, omega and four
// wheel limits, all signed Q4.11. Output word (m_axis): success flag, final
// scale step k, the four wheel speeds scaled by k/NUM_STEPS and saturated,
// and the per-wheel pass flags of the latest failing step.
// One command is in flight at a time. After a word is taken the block forms
// the five coefficient products on one shared multiplier, then the wheel
// sums, then issues one scale step per cycle, from NUM_STEPS down, into a
// four-stage scaling pipeline per wheel. The step loop sets how long a
// command takes; the next word can be taken in the cycle after the result
// is delivered.
// While the receiver stalls, the result word holds and no input is taken.
// Reset clears the controller, the in-flight steps and the kept pass flags;
// pass flags persist across commands and change only on failing steps.

module omni_wheel_speed_limit_scaler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // vel_x, vel_y, omega, wheel_limit_0, wheel_limit_1, wheel_limit_2, wheel_limit_3
    input  logic [owsls_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // success, scale_step, wheel_speed_0..3, pass_flags, zero pad
    output logic [owsls_pkg::OUT_W-1:0]    m_axis_tdata
);
    import owsls_pkg::*;

    cmd_t cmd;
    sts_t sts;

    logic signed [VALUE_WIDTH-1:0] vel_x, vel_y, omega;
    logic signed [VALUE_WIDTH-1:0] wheel_limit [NUM_WHEELS];
    logic                          success;
    logic [STEP_W-1:0]             scale_step;
    logic signed [VALUE_WIDTH-1:0] wheel_speed [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]         pass_flags;

    always_comb
    begin
        vel_x = s_axis_tdata[0*VALUE_WIDTH +: VALUE_WIDTH];
        vel_y = s_axis_tdata[1*VALUE_WIDTH +: VALUE_WIDTH];
        omega = s_axis_tdata[2*VALUE_WIDTH +: VALUE_WIDTH];
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            wheel_limit[i] = s_axis_tdata[(3+i)*VALUE_WIDTH +: VALUE_WIDTH];
        end
    end

    owsls_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    owsls_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .omega       (omega),
        .wheel_limit (wheel_limit),
        .success     (success),
        .scale_step  (scale_step),
        .wheel_speed (wheel_speed),
        .pass_flags  (pass_flags)
    );

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[0] = success;
        m_axis_tdata[7:1] = 7'(scale_step);
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            m_axis_tdata[8 + i*VALUE_WIDTH +: VALUE_WIDTH] = wheel_speed[i];
        end
        m_axis_tdata[8 + NUM_WHEELS*VALUE_WIDTH +: NUM_WHEELS] = pass_flags;
    end

endmodule
